[hw/rtl/wcsd_pkg.sv]
// wcsd_pkg: shared types, word codes and word position tables for the
// word clock span decoder. No dependencies; used by every module of the block.
`default_nettype none

package wcsd_pkg;

    // matrix geometry
    localparam int GRID       = 13;
    localparam int LAST_ROW   = 12;
    localparam int LIST_DEPTH = 9;
    localparam int QUEUE_DEPTH = 2;

    // greeting periods
    localparam logic [2:0] PER_MORNING   = 3'd0;
    localparam logic [2:0] PER_AFTERNOON = 3'd1;
    localparam logic [2:0] PER_EVENING   = 3'd2;
    localparam logic [2:0] PER_NIGHT     = 3'd3;
    localparam logic [2:0] PER_NONE      = 3'd4;

    // colour codes
    localparam logic [2:0] COL_TIME    = 3'd0;
    localparam logic [2:0] COL_AM      = 3'd1;
    localparam logic [2:0] COL_PM      = 3'd2;
    localparam logic [2:0] COL_GREET   = 3'd3;

    // five-minute phrase codes
    localparam logic [2:0] D_OCLOCK     = 3'd0;
    localparam logic [2:0] D_FIVE       = 3'd1;
    localparam logic [2:0] D_TEN        = 3'd2;
    localparam logic [2:0] D_QUARTER    = 3'd3;
    localparam logic [2:0] D_TWENTY     = 3'd4;
    localparam logic [2:0] D_TWENTYFIVE = 3'd5;
    localparam logic [2:0] D_HALF       = 3'd6;

    typedef logic [4:0] word_id_t;

    // word codes; hour words and greetings follow as blocks
    localparam word_id_t W_IT      = 5'd0;
    localparam word_id_t W_IS      = 5'd1;
    localparam word_id_t W_ALMOST  = 5'd2;
    localparam word_id_t W_OCLOCK  = 5'd3;
    localparam word_id_t W_FIVE    = 5'd4;
    localparam word_id_t W_MINUTES = 5'd5;
    localparam word_id_t W_TEN     = 5'd6;
    localparam word_id_t W_A       = 5'd7;
    localparam word_id_t W_QUARTER = 5'd8;
    localparam word_id_t W_TWENTY  = 5'd9;
    localparam word_id_t W_HALF    = 5'd10;
    localparam word_id_t W_PAST    = 5'd11;
    localparam word_id_t W_TO      = 5'd12;
    localparam word_id_t W_AM      = 5'd13;
    localparam word_id_t W_PM      = 5'd14;
    localparam word_id_t W_HOUR_BASE  = 5'd16;
    localparam word_id_t W_GREET_BASE = 5'd28;

    // hour words by hour mod 12 (twelve first)
    localparam logic [3:0] HOUR_ROW [12] =
        '{4'd8, 4'd4, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd8};
    localparam logic [3:0] HOUR_FIRST [12] =
        '{4'd7, 4'd9, 4'd0, 4'd3, 4'd8, 4'd0, 4'd5, 4'd8, 4'd0, 4'd5, 4'd9, 4'd0};
    localparam logic [3:0] HOUR_LAST [12] =
        '{4'd12, 4'd11, 4'd2, 4'd7, 4'd11, 4'd3, 4'd7, 4'd12, 4'd4, 4'd8, 4'd11, 4'd5};

    // greeting words by period
    localparam logic [3:0] GREET_ROW   [4] = '{4'd10, 4'd11, 4'd12, 4'd12};
    localparam logic [3:0] GREET_FIRST [4] = '{4'd0, 4'd0, 4'd0, 4'd8};
    localparam logic [3:0] GREET_LAST  [4] = '{4'd11, 4'd8, 4'd6, 4'd12};

    // classified time update passed from front to back
    typedef struct packed {
        logic       greet;
        logic [1:0] period;
        logic       almost;
        logic [2:0] disp;
        logic       use_to;
        logic [3:0] h12;
        logic       pm;
    } desc_t;

    typedef struct packed {
        word_id_t [LIST_DEPTH-1:0] words;
        logic [3:0]                len;
    } word_list_t;

    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] hi;
        logic [2:0] colour;
    } span_t;

    typedef struct packed {
        logic [3:0] row;
        logic [3:0] first;
        logic [3:0] last;
        logic [2:0] colour;
    } word_loc_t;

    // greeting period of an hour
    function automatic logic [2:0] period_of(input logic [4:0] h);
        logic [2:0] p;
        p = PER_NONE;
        if (h >= 5'd5 && h <= 5'd11) p = PER_MORNING;
        else if (h >= 5'd12 && h <= 5'd15) p = PER_AFTERNOON;
        else if (h >= 5'd16 && h <= 5'd20) p = PER_EVENING;
        else if ((h >= 5'd21 && h <= 5'd23) || h <= 5'd1) p = PER_NIGHT;
        return p;
    endfunction

    // logical row and columns of a word
    function automatic word_loc_t word_loc(input word_id_t id);
        word_loc_t  w;
        logic [4:0] off;
        w   = '{row: 4'd3, first: 4'd0, last: 4'd3, colour: COL_TIME};
        off = 5'd0;
        if (id >= W_GREET_BASE)
        begin
            off = id - W_GREET_BASE;
            w.row    = GREET_ROW[off[1:0]];
            w.first  = GREET_FIRST[off[1:0]];
            w.last   = GREET_LAST[off[1:0]];
            w.colour = COL_GREET + {1'b0, off[1:0]};
        end
        else if (id >= W_HOUR_BASE)
        begin
            off = id - W_HOUR_BASE;
            w.row   = HOUR_ROW[off[3:0]];
            w.first = HOUR_FIRST[off[3:0]];
            w.last  = HOUR_LAST[off[3:0]];
        end
        else
        begin
            case (id)
                W_IT:      w = '{4'd0, 4'd0, 4'd1, COL_TIME};
                W_IS:      w = '{4'd0, 4'd3, 4'd4, COL_TIME};
                W_ALMOST:  w = '{4'd0, 4'd6, 4'd11, COL_TIME};
                W_OCLOCK:  w = '{4'd9, 4'd2, 4'd7, COL_TIME};
                W_FIVE:    w = '{4'd2, 4'd6, 4'd9, COL_TIME};
                W_MINUTES: w = '{4'd3, 4'd5, 4'd11, COL_TIME};
                W_TEN:     w = '{4'd1, 4'd10, 4'd12, COL_TIME};
                W_A:       w = '{4'd1, 4'd0, 4'd0, COL_TIME};
                W_QUARTER: w = '{4'd1, 4'd2, 4'd8, COL_TIME};
                W_TWENTY:  w = '{4'd2, 4'd0, 4'd5, COL_TIME};
                W_HALF:    w = '{4'd3, 4'd0, 4'd3, COL_TIME};
                W_PAST:    w = '{4'd4, 4'd0, 4'd3, COL_TIME};
                W_TO:      w = '{4'd4, 4'd6, 4'd7, COL_TIME};
                W_AM:      w = '{4'd9, 4'd9, 4'd10, COL_AM};
                W_PM:      w = '{4'd9, 4'd11, 4'd12, COL_PM};
                default:   w = '{4'd3, 4'd0, 4'd3, COL_TIME};
            endcase
        end
        return w;
    endfunction

    // physical span of a word on the serpentine matrix
    function automatic span_t word_span(input word_id_t id);
        word_loc_t  w;
        logic [3:0] pr;
        logic [7:0] base;
        span_t      s;
        w    = word_loc(id);
        pr   = 4'(LAST_ROW) - w.row;
        base = 8'({4'd0, pr} * 8'(GRID));
        if (!pr[0])
        begin
            s.lo = base + {4'd0, w.first};
            s.hi = base + {4'd0, w.last};
        end
        else
        begin
            s.lo = base + {4'd0, 4'(LAST_ROW) - w.last};
            s.hi = base + {4'd0, 4'(LAST_ROW) - w.first};
        end
        s.colour = w.colour;
        return s;
    endfunction

    // ordered list of words lit for one update
    function automatic word_list_t build_list(input desc_t d);
        word_list_t l;
        logic [3:0] n;
        l.words = '0;
        n       = 4'd0;
        if (d.greet)
        begin
            l.words[0] = W_GREET_BASE + {3'd0, d.period};
            n = 4'd1;
        end
        else
        begin
            l.words[n] = W_IT; n = n + 4'd1;
            l.words[n] = W_IS; n = n + 4'd1;
            if (d.almost)
            begin
                l.words[n] = W_ALMOST; n = n + 4'd1;
            end
            case (d.disp)
                D_OCLOCK:
                begin
                    l.words[n] = W_OCLOCK; n = n + 4'd1;
                end
                D_FIVE:
                begin
                    l.words[n] = W_FIVE; n = n + 4'd1;
                    l.words[n] = W_MINUTES; n = n + 4'd1;
                end
                D_TEN:
                begin
                    l.words[n] = W_TEN; n = n + 4'd1;
                    l.words[n] = W_MINUTES; n = n + 4'd1;
                end
                D_QUARTER:
                begin
                    l.words[n] = W_A; n = n + 4'd1;
                    l.words[n] = W_QUARTER; n = n + 4'd1;
                end
                D_TWENTY:
                begin
                    l.words[n] = W_TWENTY; n = n + 4'd1;
                    l.words[n] = W_MINUTES; n = n + 4'd1;
                end
                D_TWENTYFIVE:
                begin
                    l.words[n] = W_TWENTY; n = n + 4'd1;
                    l.words[n] = W_FIVE; n = n + 4'd1;
                    l.words[n] = W_MINUTES; n = n + 4'd1;
                end
                default:
                begin
                    l.words[n] = W_HALF; n = n + 4'd1;
                end
            endcase
            if (d.disp != D_OCLOCK)
            begin
                l.words[n] = d.use_to ? W_TO : W_PAST;
                n = n + 4'd1;
            end
            l.words[n] = W_HOUR_BASE + {1'b0, d.h12}; n = n + 4'd1;
            l.words[n] = d.pm ? W_PM : W_AM; n = n + 4'd1;
        end
        l.len = n;
        return l;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/wcsd_front.sv]
// wcsd_front: accepts time updates, tracks the greeting state and classifies
// each update into a descriptor. Depends on wcsd_pkg.
`default_nettype none

module wcsd_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire logic [4:0]     hour,
    input  wire logic [5:0]     minute,
    output wcsd_pkg::desc_t     desc
);

    logic [2:0] period_reg, period_next;
    logic       done_reg, done_next;

    logic [2:0] per;
    logic       done_eff;
    logic       greet;
    logic [5:0] m_c;
    logic [9:0] prod_q, prod_k;
    logic [3:0] q5, k5;
    logic [5:0] rem5;
    logic [5:0] h_adj;
    logic [5:0] h24;
    logic [2:0] disp;
    logic       use_to;
    logic       offset;

    // greeting decision
    always_comb
    begin
        per      = wcsd_pkg::period_of(hour);
        done_eff = (per == period_reg) ? done_reg : 1'b0;
        greet    = (per != wcsd_pkg::PER_NONE) && !done_eff && (minute == 6'd0);
        period_next = per;
        done_next   = done_eff | greet;
    end

    // minute bucket, reciprocal of five as 13/64 for values up to 61
    always_comb
    begin
        m_c    = (minute > 6'd59) ? 6'd59 : minute;
        prod_q = {4'd0, m_c} * 10'd13;
        q5     = prod_q[9:6];
        rem5   = m_c - 6'({2'd0, q5} * 6'd5);
        prod_k = {4'd0, m_c + 6'd2} * 10'd13;
        k5     = prod_k[9:6];
        if (k5 == 4'd12) begin
            disp   = wcsd_pkg::D_OCLOCK;
            use_to = 1'b0;
            offset = 1'b1;
        end else if (k5 > 4'd6) begin
            disp   = 3'(4'd12 - k5);
            use_to = 1'b1;
            offset = 1'b1;
        end else begin
            disp   = k5[2:0];
            use_to = 1'b0;
            offset = 1'b0;
        end
    end

    // hour word and am/pm
    always_comb
    begin
        h_adj = {1'b0, hour} + {5'd0, offset};
        h24   = (h_adj >= 6'd24) ? h_adj - 6'd24 : h_adj;
        desc.greet  = greet;
        desc.period = per[1:0];
        desc.almost = rem5 >= 6'd3;
        desc.disp   = disp;
        desc.use_to = use_to;
        desc.pm     = h24 >= 6'd12;
        if (h_adj >= 6'd24)
            desc.h12 = 4'(h_adj - 6'd24);
        else if (h_adj >= 6'd12)
            desc.h12 = 4'(h_adj - 6'd12);
        else
            desc.h12 = h_adj[3:0];
    end

    // greeting state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= wcsd_pkg::PER_NONE;
            done_reg   <= 1'b0;
        end
        else if (push)
        begin
            period_reg <= period_next;
            done_reg   <= done_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/wcsd_queue.sv]
// wcsd_queue: two-entry descriptor queue between front and back.
// Depends on wcsd_pkg.
`default_nettype none

module wcsd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wcsd_pkg::desc_t     push_desc,
    output logic                full,
    input  wire logic           pop,
    output logic                head_valid,
    output wcsd_pkg::desc_t     head_desc
);

    wcsd_pkg::desc_t slots_reg [wcsd_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = count_reg == 2'(wcsd_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != 2'd0;
    assign head_desc  = slots_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

`default_nettype wire

[hw/rtl/wcsd_back.sv]
// wcsd_back: expands one descriptor into its word list and, while the sink is
// ready, emits one span per cycle via an output register. Depends on wcsd_pkg.
`default_nettype none

module wcsd_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wcsd_pkg::desc_t     q_desc,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          led_low,
    output logic [7:0]          led_high,
    output logic [2:0]          colour_code,
    output logic                last_span
);

    logic                 active_reg, active_next;
    wcsd_pkg::word_id_t [wcsd_pkg::LIST_DEPTH-1:0] words_reg;
    logic [3:0]           len_reg;
    logic [3:0]           idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           low_reg, high_reg;
    logic [2:0]           colour_reg;
    logic                 last_reg;

    wcsd_pkg::word_list_t list_new;
    wcsd_pkg::span_t      span;
    logic                 last_now;
    logic                 out_load;

    assign list_new = wcsd_pkg::build_list(q_desc);
    assign span     = wcsd_pkg::word_span(words_reg[idx_reg]);
    assign last_now = idx_reg == (len_reg - 4'd1);
    assign out_load = active_reg && (!out_valid_reg || out_ready);
    assign pop      = q_valid && (!active_reg || (out_load && last_now));

    // sequencer over the word list
    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        if (pop)
        begin
            active_next = 1'b1;
            idx_next    = 4'd0;
        end
        else if (out_load)
        begin
            if (last_now)
                active_next = 1'b0;
            else
                idx_next = idx_reg + 4'd1;
        end
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // word list and output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            words_reg <= list_new.words;
            len_reg   <= list_new.len;
        end
        if (out_load)
        begin
            low_reg    <= span.lo;
            high_reg   <= span.hi;
            colour_reg <= span.colour;
            last_reg   <= last_now;
        end
    end

    assign out_valid   = out_valid_reg;
    assign led_low     = low_reg;
    assign led_high    = high_reg;
    assign colour_code = colour_reg;
    assign last_span   = last_reg;

    // list position stays inside a non-empty list
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (len_reg != 4'd0 && idx_reg < len_reg &&
                        len_reg <= 4'(wcsd_pkg::LIST_DEPTH)))
        else $error("span index outside word list");

    // final span with nothing queued leaves the sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_now && !q_valid) |=> !active_reg)
        else $error("sequencer stayed busy after final span");

    // a non-final span advances by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !last_now) |=> (active_reg && idx_reg == $past(idx_reg) + 4'd1))
        else $error("span index did not advance");

    // a loaded final span carries the last span flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_now) |=> (out_valid_reg && last_reg))
        else $error("final span not flagged");

endmodule

`default_nettype wire

[hw/rtl/word_clock_span_decoder_top.sv]
// word_clock_span_decoder_top: top level of the word clock span decoder.
// Depends on wcsd_pkg, wcsd_front, wcsd_queue and wcsd_back.
`default_nettype none

// Each accepted time request (hour, minute) yields one to nine lit word spans
// on the 13x13 serpentine matrix, one span per clock while the sink is ready,
// on the result channel, last_span marking the final one; all of them come
// from the single span emitter in the back part.
// The front takes a request every cycle while the two-entry descriptor queue
// has room, updating the greeting state at acceptance, so requests may be
// issued back to back and the next update's spans follow the previous
// update's last span with no gap. Results sit in an output register, so the
// sink may stall at any time without loss.
module word_clock_span_decoder_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [4:0] hour,
    input  wire logic [5:0] minute,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      led_low,
    output logic [7:0]      led_high,
    output logic [2:0]      colour_code,
    output logic            last_span
);

    wcsd_pkg::desc_t front_desc;
    wcsd_pkg::desc_t head_desc;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    logic            push;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    // classification of incoming requests
    wcsd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .hour   (hour),
        .minute (minute),
        .desc   (front_desc)
    );

    // decoupling queue
    wcsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (front_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_desc  (head_desc)
    );

    // span emission
    wcsd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_desc      (head_desc),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .led_low     (led_low),
        .led_high    (led_high),
        .colour_code (colour_code),
        .last_span   (last_span)
    );

endmodule

`default_nettype wire
